FILE: src/cdg_pkg.sv
`default_nettype none

package cdg_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned FillW      = $clog2(TableDepth + 1);
  localparam int unsigned IdW        = 32;
  localparam int unsigned CountW     = 16;
  localparam logic [CountW-1:0] ReloadReset = 16'd1440;

  typedef enum logic [2:0] {
    OpTick       = 3'd0,
    OpReload     = 3'd1,
    OpRegister   = 3'd2,
    OpUnregister = 3'd3,
    OpRecover    = 3'd4,
    OpCheck      = 3'd5
  } cdg_op_e;

  typedef enum logic [1:0] {
    ModeMonitoring  = 2'd0,
    ModeCompromised = 2'd1,
    ModeRecovering  = 2'd2
  } cdg_mode_e;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SLast,
    SDone
  } cdg_state_e;

  typedef struct packed {
    logic [2:0]     req_type;
    logic [IdW-1:0] process_id;
  } cdg_req_t;

  typedef struct packed {
    logic [CountW-1:0] remaining_minutes;
    logic [1:0]        system_state;
    logic [6:0]        entry_count;
    logic              deny_terminate;
  } cdg_res_t;

  typedef struct packed {
    logic           valid;
    logic [2:0]     op;
    logic [IdW-1:0] id;
  } cdg_tbl_cmd_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [FillW-1:0] fill;
  } cdg_tbl_rsp_t;

endpackage

`default_nettype wire

FILE: src/countdown_guard_with_id_table_core.sv
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// request   | start in, busy out        | req_i  (req_type, process_id)
// result    | done_o strobe, one cycle  | res_o  (minutes, state, count, deny)
// config    | cfg_valid_i / cfg_ready_o | cfg_data_i (reload_minutes)
//
// tick, reload, recovery, register: result via the SDone state and the done_q register
// check, unregister: table scan at one entry per cycle through the single
// read port of the id memory
// busy stays high from the accepting edge until the result is registered
// reset: countdown 1440, monitoring, empty table; no clearing pass
// results cannot be stalled; the done_o strobe marks them for one cycle only
`default_nettype none

module countdown_guard_with_id_table_core
  import cdg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire cdg_req_t          req_i,
  output logic                   done_o,
  output cdg_res_t               res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CountW-1:0] cfg_data_i
);

  logic              busy_q, busy_d;
  logic              done_q;
  cdg_res_t          res_q;
  logic [CountW-1:0] reload_q;
  logic [CountW-1:0] count_q, count_d;
  cdg_mode_e         mode_q, mode_d;
  logic              accept;
  cdg_tbl_cmd_t      tbl_cmd;
  cdg_tbl_rsp_t      tbl_rsp;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  assign tbl_cmd.valid = accept;
  assign tbl_cmd.op    = req_i.req_type;
  assign tbl_cmd.id    = req_i.process_id;

  cdg_id_search u_search (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (tbl_cmd),
    .rsp_o (tbl_rsp)
  );

  always_comb begin
    count_d = count_q;
    mode_d  = mode_q;
    busy_d  = busy_q;
    if (tbl_rsp.done) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      case (req_i.req_type)
        OpTick: begin
          if (count_q != '0) begin
            count_d = count_q - CountW'(1);
          end
          if (count_q <= CountW'(1)) begin
            mode_d = ModeCompromised;
          end
        end
        OpReload: begin
          count_d = reload_q;
          mode_d  = ModeMonitoring;
        end
        OpRecover: mode_d = ModeRecovering;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      reload_q <= ReloadReset;
      count_q  <= ReloadReset;
      mode_q   <= ModeMonitoring;
    end else begin
      busy_q  <= busy_d;
      done_q  <= tbl_rsp.done;
      count_q <= count_d;
      mode_q  <= mode_d;
      if (cfg_valid_i && cfg_ready_o) begin
        reload_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_rsp.done) begin
      res_q.remaining_minutes <= count_q;
      res_q.system_state      <= mode_q;
      res_q.entry_count       <= 7'(tbl_rsp.fill);
      res_q.deny_terminate    <= tbl_rsp.hit && (mode_q == ModeMonitoring);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy not raised after request");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("result strobe while busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe repeated");

  a_deny_monitoring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.deny_terminate) |-> (res_q.system_state == ModeMonitoring))
    else $error("deny outside monitoring");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_rsp.done |-> (tbl_rsp.fill <= FillW'(TableDepth)))
    else $error("table fill beyond depth");

endmodule

`default_nettype wire

FILE: src/cdg_id_ram.sv
`default_nettype none

module cdg_id_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/cdg_id_search.sv
`default_nettype none

module cdg_id_search
  import cdg_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cdg_tbl_cmd_t cmd_i,
  output cdg_tbl_rsp_t      rsp_o
);

  cdg_state_e       state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]  match_idx_q, match_idx_d;
  logic [IdW-1:0]   id_q, id_d;
  logic             unreg_q, unreg_d;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [IdW-1:0]   ram_wdata;
  logic             ram_re;
  logic [IdxW-1:0]  ram_raddr;
  logic [IdW-1:0]   ram_rdata;

  logic             full;
  logic             hit_now;
  logic [FillW-1:0] last_pos;

  assign full     = (fill_q == FillW'(TableDepth));
  assign hit_now  = cmp_vld_q && (ram_rdata == id_q);
  assign last_pos = fill_q - FillW'(1);

  cdg_id_ram #(
    .Depth(TableDepth),
    .Width(IdW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    match_idx_q <= match_idx_d;
    id_q        <= id_d;
    unreg_q     <= unreg_d;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    match_idx_d = match_idx_q;
    id_d        = id_q;
    unreg_d     = unreg_q;
    ram_we      = 1'b0;
    ram_waddr   = fill_q[IdxW-1:0];
    ram_wdata   = id_q;
    ram_re      = 1'b0;
    ram_raddr   = rd_idx_q[IdxW-1:0];
    rsp_o.done  = 1'b0;
    rsp_o.hit   = 1'b0;

    case (state_q)
      SIdle: begin
        if (cmd_i.valid) begin
          id_d    = cmd_i.id;
          unreg_d = (cmd_i.op == OpUnregister);
          case (cmd_i.op)
            OpRegister: begin
              if (!full) begin
                ram_we    = 1'b1;
                ram_wdata = cmd_i.id;
                fill_d    = fill_q + FillW'(1);
              end
              state_d = SDone;
            end
            OpUnregister, OpCheck: begin
              rd_idx_d = '0;
              state_d  = SScan;
            end
            default: state_d = SDone;
          endcase
        end
      end
      SScan: begin
        if (hit_now) begin
          if (unreg_q) begin
            ram_re      = 1'b1;
            ram_raddr   = last_pos[IdxW-1:0];
            match_idx_d = cmp_idx_q;
            state_d     = SLast;
          end else begin
            rsp_o.done = 1'b1;
            rsp_o.hit  = 1'b1;
            state_d    = SIdle;
          end
        end else if (rd_idx_q == fill_q) begin
          rsp_o.done = 1'b1;
          state_d    = SIdle;
        end else begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IdxW-1:0];
          rd_idx_d  = rd_idx_q + FillW'(1);
        end
      end
      SLast: begin
        // move the last entry into the freed slot
        ram_we     = 1'b1;
        ram_waddr  = match_idx_q;
        ram_wdata  = ram_rdata;
        fill_d     = last_pos;
        rsp_o.done = 1'b1;
        state_d    = SIdle;
      end
      SDone: begin
        rsp_o.done = 1'b1;
        state_d    = SIdle;
      end
      default: state_d = SIdle;
    endcase

    rsp_o.fill = fill_d;
  end

endmodule

`default_nettype wire
